FILE: sv/cpd_pkg.sv
// package for the channel packet deframer
// holds parse phase, result kind and error codes, the result struct and header constants
// no dependencies
package cpd_pkg;

    // number of channels that may be enabled for reading
    localparam int CHANNELS = 64;

    // header size in bytes, and the length-code escape values
    localparam logic [31:0] HDR_BYTES  = 32'd8;
    localparam logic [7:0]  ESC_BYTE   = 8'hFF;
    localparam logic [15:0] ESC_SHORT  = 16'hFFFF;

    // parse phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_CHANNEL = 5'b00100,
        PH_CODE    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    // result kind
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_NEG_LENGTH = 3'd1,
        ERR_EMPTY_BODY = 3'd2,
        ERR_WRONG_CHAN = 3'd3,
        ERR_TRUNCATED  = 3'd4,
        ERR_MISALIGNED = 3'd5
    } t_err;

    // one result item
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  channel;
        logic [7:0]  data;
        logic [31:0] record_length;
        logic [15:0] peer_time;
        logic [15:0] ping;
        logic        last;
        t_err        error_code;
    } t_result;

endpackage

FILE: sv/cpd_parse.sv
// parse state and per-byte next-state logic of the channel packet deframer
// holds the read channel mask; produces at most one result per accepted byte
// depends on cpd_pkg
module cpd_parse #(
    parameter int CHANNELS = cpd_pkg::CHANNELS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [63:0]      i_cfg_data,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_first_of_packet,
    input  logic [15:0]      i_now_time,
    output logic             o_res_valid,
    output cpd_pkg::t_result o_res
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    cpd_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_byte_index, n_byte_index;
    logic [31:0]     r_packet_left, n_packet_left;
    logic [31:0]     r_record_left, n_record_left;
    logic [31:0]     r_length_accum, n_length_accum;
    logic [7:0]      r_current_channel, n_current_channel;
    logic [15:0]     r_header_time, n_header_time;
    logic [CHANNELS-1:0] r_mask;

    // channel enable check
    logic chan_ok;
    assign chan_ok = ({1'b0, i_rx_byte} < 9'(CHANNELS)) && r_mask[i_rx_byte[IDX_W-1:0]];

    // next state and result
    always_comb begin
        cpd_pkg::t_phase ph;
        logic [2:0]  bi;
        logic        fin;
        logic [31:0] fin_len;
        logic [31:0] acc;
        logic [15:0] echo;

        n_phase           = r_phase;
        n_byte_index      = r_byte_index;
        n_packet_left     = r_packet_left;
        n_record_left     = r_record_left;
        n_length_accum    = r_length_accum;
        n_current_channel = r_current_channel;
        n_header_time     = r_header_time;
        o_res_valid       = 1'b0;
        o_res             = '0;
        fin               = 1'b0;
        fin_len           = '0;
        acc               = r_length_accum;
        echo              = '0;
        ph                = r_phase;
        bi                = r_byte_index;

        // start of packet restarts the header whatever was in progress
        if (i_first_of_packet) begin
            ph           = cpd_pkg::PH_HEADER;
            bi           = '0;
            n_phase      = cpd_pkg::PH_HEADER;
            n_byte_index = '0;
        end

        case (ph)
            cpd_pkg::PH_HEADER: begin
                n_byte_index = bi + 3'd1;
                case (bi)
                    3'd0: n_length_accum = {24'd0, i_rx_byte};
                    3'd1: n_length_accum = {r_length_accum[31:16], i_rx_byte,
                                            r_length_accum[7:0]};
                    3'd2: n_length_accum = {r_length_accum[31:24], i_rx_byte,
                                            r_length_accum[15:0]};
                    3'd3: begin
                        acc            = {i_rx_byte, r_length_accum[23:0]};
                        n_length_accum = acc;
                        // total length negative or shorter than the header
                        if (acc[31] || (acc < cpd_pkg::HDR_BYTES)) begin
                            n_phase          = cpd_pkg::PH_IDLE;
                            o_res_valid      = 1'b1;
                            o_res.kind       = cpd_pkg::KIND_ERROR;
                            o_res.error_code = cpd_pkg::ERR_NEG_LENGTH;
                        end else begin
                            n_packet_left = acc - cpd_pkg::HDR_BYTES;
                        end
                    end
                    3'd4: n_header_time = {8'd0, i_rx_byte};
                    3'd5: n_header_time = {i_rx_byte, r_header_time[7:0]};
                    3'd6: n_length_accum = {24'd0, i_rx_byte};
                    default: begin
                        // last header byte: report remote time and ping
                        echo              = {i_rx_byte, r_length_accum[7:0]};
                        o_res_valid       = 1'b1;
                        o_res.peer_time   = r_header_time;
                        o_res.ping        = i_now_time - echo;
                        if (r_packet_left == '0) begin
                            n_phase          = cpd_pkg::PH_IDLE;
                            o_res.kind       = cpd_pkg::KIND_ERROR;
                            o_res.error_code = cpd_pkg::ERR_EMPTY_BODY;
                        end else begin
                            n_phase    = cpd_pkg::PH_CHANNEL;
                            o_res.kind = cpd_pkg::KIND_HEADER;
                        end
                    end
                endcase
            end

            cpd_pkg::PH_CHANNEL: begin
                if (!chan_ok) begin
                    n_phase          = cpd_pkg::PH_IDLE;
                    o_res_valid      = 1'b1;
                    o_res.kind       = cpd_pkg::KIND_ERROR;
                    o_res.channel    = i_rx_byte;
                    o_res.error_code = cpd_pkg::ERR_WRONG_CHAN;
                end else begin
                    n_current_channel = i_rx_byte;
                    n_packet_left     = r_packet_left - 32'd1;
                    if (r_packet_left == 32'd1) begin
                        // no room for a length code
                        n_phase          = cpd_pkg::PH_IDLE;
                        o_res_valid      = 1'b1;
                        o_res.kind       = cpd_pkg::KIND_ERROR;
                        o_res.channel    = i_rx_byte;
                        o_res.error_code = cpd_pkg::ERR_TRUNCATED;
                    end else begin
                        n_phase      = cpd_pkg::PH_CODE;
                        n_byte_index = '0;
                    end
                end
            end

            cpd_pkg::PH_CODE: begin
                n_packet_left = r_packet_left - 32'd1;
                n_byte_index  = bi + 3'd1;
                case (bi)
                    3'd0: begin
                        if (i_rx_byte != cpd_pkg::ESC_BYTE) begin
                            fin     = 1'b1;
                            fin_len = {24'd0, i_rx_byte};
                        end else if (r_packet_left < 32'd3) begin
                            n_phase          = cpd_pkg::PH_IDLE;
                            o_res_valid      = 1'b1;
                            o_res.kind       = cpd_pkg::KIND_ERROR;
                            o_res.channel    = r_current_channel;
                            o_res.error_code = cpd_pkg::ERR_TRUNCATED;
                        end
                    end
                    3'd1: n_length_accum = {24'd0, i_rx_byte};
                    3'd2: begin
                        acc            = {16'd0, i_rx_byte, r_length_accum[7:0]};
                        n_length_accum = acc;
                        if (acc[15:0] != cpd_pkg::ESC_SHORT) begin
                            fin     = 1'b1;
                            fin_len = acc;
                        end else if (r_packet_left < 32'd5) begin
                            n_phase          = cpd_pkg::PH_IDLE;
                            o_res_valid      = 1'b1;
                            o_res.kind       = cpd_pkg::KIND_ERROR;
                            o_res.channel    = r_current_channel;
                            o_res.error_code = cpd_pkg::ERR_TRUNCATED;
                        end
                    end
                    3'd3: n_length_accum = {24'd0, i_rx_byte};
                    3'd4: n_length_accum = {r_length_accum[31:16], i_rx_byte,
                                            r_length_accum[7:0]};
                    3'd5: n_length_accum = {r_length_accum[31:24], i_rx_byte,
                                            r_length_accum[15:0]};
                    default: begin
                        fin     = 1'b1;
                        fin_len = {i_rx_byte, r_length_accum[23:0]};
                    end
                endcase

                // length code complete: len > left-after-this-byte is len >= left now
                if (fin) begin
                    if (fin_len >= r_packet_left) begin
                        n_phase             = cpd_pkg::PH_IDLE;
                        o_res_valid         = 1'b1;
                        o_res.kind          = cpd_pkg::KIND_ERROR;
                        o_res.channel       = r_current_channel;
                        o_res.record_length = fin_len;
                        o_res.error_code    = cpd_pkg::ERR_MISALIGNED;
                    end else if (fin_len == '0) begin
                        n_phase       = (r_packet_left != 32'd1) ? cpd_pkg::PH_CHANNEL
                                                                 : cpd_pkg::PH_IDLE;
                        o_res_valid   = 1'b1;
                        o_res.kind    = cpd_pkg::KIND_EMPTY;
                        o_res.channel = r_current_channel;
                    end else begin
                        n_record_left  = fin_len;
                        n_length_accum = fin_len;
                        n_phase        = cpd_pkg::PH_PAYLOAD;
                    end
                end
            end

            cpd_pkg::PH_PAYLOAD: begin
                if (r_record_left != '0) begin
                    n_record_left = r_record_left - 32'd1;
                end
                if (r_packet_left != '0) begin
                    n_packet_left = r_packet_left - 32'd1;
                end
                o_res_valid         = 1'b1;
                o_res.kind          = cpd_pkg::KIND_PAYLOAD;
                o_res.channel       = r_current_channel;
                o_res.data          = i_rx_byte;
                o_res.record_length = r_length_accum;
                // last byte of the record
                if (r_record_left[31:1] == '0) begin
                    o_res.last = 1'b1;
                    n_phase    = (r_packet_left[31:1] != '0) ? cpd_pkg::PH_CHANNEL
                                                             : cpd_pkg::PH_IDLE;
                end
            end

            default: begin
                n_phase = cpd_pkg::PH_IDLE;
            end
        endcase
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= cpd_pkg::PH_IDLE;
            r_byte_index      <= '0;
            r_packet_left     <= '0;
            r_record_left     <= '0;
            r_length_accum    <= '0;
            r_current_channel <= '0;
            r_header_time     <= '0;
        end else if (i_accept) begin
            r_phase           <= n_phase;
            r_byte_index      <= n_byte_index;
            r_packet_left     <= n_packet_left;
            r_record_left     <= n_record_left;
            r_length_accum    <= n_length_accum;
            r_current_channel <= n_current_channel;
            r_header_time     <= n_header_time;
        end
    end

    // read channel mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_data[CHANNELS-1:0];
        end
    end

endmodule

FILE: sv/cpd_out_reg.sv
// result register of the channel packet deframer
// holds one result request until the downstream side takes it
// depends on cpd_pkg
module cpd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_res_valid,
    input  cpd_pkg::t_result i_res,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_room,
    output cpd_pkg::t_result o_res
);

    logic             r_valid;
    cpd_pkg::t_result r_res;

    // room for a new result when empty or being taken this cycle
    assign o_room      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: sv/channel_packet_deframer_core.sv
// top level of the channel packet deframer
// joins the parse stage and the result register; depends on cpd_pkg, cpd_parse, cpd_out_reg

// Takes one received byte per cycle while the result register is empty or its request is
// being taken, so the sustained rate is one byte per clock, set by the single parse stage.
// It returns at most one result per byte, in the cycle after the byte is accepted. Header
// info comes on the eighth header byte, payload bytes pass one for one tagged with their
// channel, and after any error bytes are dropped until the next first-of-packet byte.
// The read channel mask is written through i_cfg_we / i_cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module channel_packet_deframer_core #(
    parameter int CHANNELS = cpd_pkg::CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_first_of_packet,
    input  logic [15:0] i_now_time,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_channel,
    output logic [7:0]  o_data,
    output logic [31:0] o_record_length,
    output logic [15:0] o_peer_time,
    output logic [15:0] o_ping,
    output logic        o_last,
    output logic [2:0]  o_error_code
);

    logic             accept;
    logic             room;
    logic             res_valid;
    cpd_pkg::t_result res;
    cpd_pkg::t_result out_res;

    assign o_in_ready = room;
    assign accept     = i_in_valid && room;

    // parse stage
    cpd_parse #(
        .CHANNELS (CHANNELS)
    ) u_parse (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_accept          (accept),
        .i_rx_byte         (i_rx_byte),
        .i_first_of_packet (i_first_of_packet),
        .i_now_time        (i_now_time),
        .o_res_valid       (res_valid),
        .o_res             (res)
    );

    // result register
    cpd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_room      (room),
        .o_res       (out_res)
    );

    // result fields
    assign o_kind          = out_res.kind;
    assign o_channel       = out_res.channel;
    assign o_data          = out_res.data;
    assign o_record_length = out_res.record_length;
    assign o_peer_time     = out_res.peer_time;
    assign o_ping          = out_res.ping;
    assign o_last          = out_res.last;
    assign o_error_code    = out_res.error_code;

endmodule
